// ===== rtl/brf_pkg.sv =====
// Shared types and constants for the block ring FIFO.
package brf_pkg;

  // Command codes carried on the cmd field.
  localparam logic [2:0] CMD_WR_SAMPLE   = 3'd0;
  localparam logic [2:0] CMD_RD_SAMPLE   = 3'd1;
  localparam logic [2:0] CMD_WR_BLOCK    = 3'd2;
  localparam logic [2:0] CMD_RD_BLOCK    = 3'd3;
  localparam logic [2:0] CMD_DROP_SAMPLE = 3'd4;
  localparam logic [2:0] CMD_DROP_BLOCK  = 3'd5;
  localparam logic [2:0] CMD_CLEAR       = 3'd6;
  localparam logic [2:0] CMD_STATUS      = 3'd7;

  // Register interface.
  localparam int          APB_AW         = 3;
  localparam logic        REG_BLOCK_SIZE = 1'b0;

  // Block size register and its legal span.
  localparam int          BS_W     = 7;
  localparam logic [6:0]  BS_RESET = 7'd16;
  localparam logic [6:0]  BS_MIN   = 7'd1;
  localparam logic [6:0]  BS_MAX   = 7'd64;

  // Width of the count fields on the result channel.
  localparam int          CNT_OUT_W = 11;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;    // latch the input transfer
    logic exec;       // execute one step of the latched command
    logic first;      // first element of a block read
    logic last;       // this step produces the final result of the item
    logic div_start;  // start the block count division
    logic push;       // load the result into the output register
  } brf_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0]      cmd;        // latched command
    logic            blk_avail;  // at least one whole block stored
    logic            out_free;   // output register can take a result
    logic            div_busy;   // block count division in progress
    logic [BS_W-1:0] bs;         // effective block size
  } brf_sts_t;

endpackage

// ===== rtl/brf_regs.sv =====
// Register port: holds block_size and derives the effective block size.
module brf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [brf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [brf_pkg::BS_W-1:0]   bs
);
  import brf_pkg::*;

  logic [BS_W-1:0] block_size;
  logic            hit;

  assign hit    = (paddr[APB_AW-1:2] == REG_BLOCK_SIZE);
  assign pready = 1'b1;

  // Register write on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BS_RESET;
    end else if (psel && penable && pwrite && hit) begin
      block_size <= pwdata[BS_W-1:0];
    end
  end

  // Read back the stored value.
  assign prdata = hit ? {{(32 - BS_W){1'b0}}, block_size} : 32'd0;

  // Zero acts as one, values above the maximum act as the maximum.
  always_comb begin
    if (block_size < BS_MIN) begin
      bs = BS_MIN;
    end else if (block_size > BS_MAX) begin
      bs = BS_MAX;
    end else begin
      bs = block_size;
    end
  end

endmodule

// ===== rtl/brf_div.sv =====
// Bit-serial divider that forms both block counts from the fill counts.
module brf_div #(
  parameter int CW = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CW-1:0]            num_a,
  input  logic [CW-1:0]            num_b,
  input  logic [brf_pkg::BS_W-1:0] den,
  output logic [CW-1:0]            quo_a,
  output logic [CW-1:0]            quo_b,
  output logic                     busy
);
  import brf_pkg::*;

  localparam int SCW = $clog2(CW + 1);

  logic [SCW-1:0]  steps;
  logic [CW-1:0]   sh_a;
  logic [CW-1:0]   sh_b;
  logic [BS_W-1:0] rem_a;
  logic [BS_W-1:0] rem_b;
  logic [BS_W:0]   trial_a;
  logic [BS_W:0]   trial_b;
  logic [BS_W:0]   den_x;
  logic            ge_a;
  logic            ge_b;

  // One quotient bit per cycle for each count.
  assign den_x   = {1'b0, den};
  assign trial_a = {rem_a, sh_a[CW-1]};
  assign trial_b = {rem_b, sh_b[CW-1]};
  assign ge_a    = (trial_a >= den_x);
  assign ge_b    = (trial_b >= den_x);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= SCW'(CW);
    end else if (steps != '0) begin
      steps <= steps - SCW'(1);
    end
  end

  // Shift registers: dividend bits leave at the top, quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      sh_a  <= num_a;
      sh_b  <= num_b;
      rem_a <= '0;
      rem_b <= '0;
    end else if (steps != '0) begin
      sh_a  <= {sh_a[CW-2:0], ge_a};
      sh_b  <= {sh_b[CW-2:0], ge_b};
      rem_a <= ge_a ? BS_W'(trial_a - den_x) : trial_a[BS_W-1:0];
      rem_b <= ge_b ? BS_W'(trial_b - den_x) : trial_b[BS_W-1:0];
    end
  end

  assign quo_a = sh_a;
  assign quo_b = sh_b;
  assign busy  = (steps != '0);

endmodule

// ===== rtl/brf_ctrl.sv =====
// Controller: sequences each command through execute, divide and output.
module brf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  brf_pkg::brf_sts_t sts,
  output brf_pkg::brf_ctl_t ctl
);
  import brf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_DIV,
    S_PUSH
  } state_t;

  state_t          state;
  logic [BS_W-1:0] elem;
  logic            more;
  logic            last_now;

  // Final result of the item: any command but a block read, a rejected
  // block read, or the last element of a block read.
  always_comb begin
    if (sts.cmd != CMD_RD_BLOCK) begin
      last_now = 1'b1;
    end else if ((elem == '0) && !sts.blk_avail) begin
      last_now = 1'b1;
    end else begin
      last_now = (BS_W'(elem + BS_W'(1)) == sts.bs);
    end
  end

  // Commands to the datapath.
  always_comb begin
    ctl.take_in   = (state == S_IDLE) && in_valid;
    ctl.exec      = (state == S_EXEC);
    ctl.first     = (elem == '0);
    ctl.last      = last_now;
    ctl.div_start = (state == S_START);
    ctl.push      = (state == S_PUSH) && sts.out_free;
  end

  assign in_stall = (state != S_IDLE);

  // State and element counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      elem  <= '0;
      more  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          more  <= !last_now;
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!sts.div_busy) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (sts.out_free) begin
            if (more) begin
              elem  <= elem + BS_W'(1);
              state <= S_EXEC;
            end else begin
              elem  <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/brf_dp.sv =====
// Datapath: sample memory, ring indices, fill count and output register.
module brf_dp #(
  parameter int DEPTH = 1024,
  parameter int CW    = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brf_pkg::brf_ctl_t             ctl,
  output brf_pkg::brf_sts_t             sts,
  input  logic [brf_pkg::BS_W-1:0]      bs,
  input  logic [2:0]                    cmd,
  input  logic [31:0]                   sample_in,
  output logic [CW-1:0]                 cnt_rd,
  output logic [CW-1:0]                 cnt_wr,
  input  logic [CW-1:0]                 quo_rd,
  input  logic [CW-1:0]                 quo_wr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [31:0]                   sample_out,
  output logic                          last,
  output logic [brf_pkg::CNT_OUT_W-1:0] samples_readable,
  output logic [brf_pkg::CNT_OUT_W-1:0] samples_writable,
  output logic [brf_pkg::CNT_OUT_W-1:0] blocks_readable,
  output logic [brf_pkg::CNT_OUT_W-1:0] blocks_writable
);
  import brf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam int XW = (CW > BS_W) ? CW : BS_W;
  localparam int OW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  logic [31:0]     mem [DEPTH];
  logic [31:0]     rdata;
  logic [2:0]      cmd_q;
  logic [31:0]     sample_q;
  logic [AW-1:0]   ridx;
  logic [AW-1:0]   widx;
  logic [CW-1:0]   cnt;
  logic [5:0]      bw_pos;
  logic            bw_ok;
  logic            res_ok;
  logic [31:0]     res_sample;
  logic            res_last;

  logic [AW-1:0]   ridx_next;
  logic [AW-1:0]   widx_next;
  logic [CW-1:0]   cnt_next;
  logic [5:0]      bw_pos_next;
  logic            bw_ok_next;
  logic            ok_next;
  logic [31:0]     sample_next;
  logic            we;

  logic [AW-1:0]   ridx_inc;
  logic [AW-1:0]   widx_inc;
  logic [SW-1:0]   ridx_sum;
  logic [AW-1:0]   ridx_blk;
  logic [CW-1:0]   free;
  logic            full;
  logic            empty;
  logic            room;
  logic            blk_avail;
  logic            blk_ok;
  logic [5:0]      pos_inc;
  logic [5:0]      pos_wrap;
  logic [OW-1:0]   rd_x;
  logic [OW-1:0]   wr_x;
  logic [OW-1:0]   qr_x;
  logic [OW-1:0]   qw_x;

  // Fill state.
  assign free      = CW'(DEPTH) - cnt;
  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);
  assign blk_avail = (XW'(cnt) >= XW'(bs));
  assign room      = (XW'(free) >= XW'(bs));

  // Index arithmetic with wrap at the ring depth.
  assign ridx_inc = (ridx == AW'(DEPTH - 1)) ? '0 : ridx + AW'(1);
  assign widx_inc = (widx == AW'(DEPTH - 1)) ? '0 : widx + AW'(1);
  assign ridx_sum = SW'(ridx) + SW'(bs);
  assign ridx_blk = (ridx_sum >= SW'(DEPTH)) ? AW'(ridx_sum - SW'(DEPTH)) : AW'(ridx_sum);

  // Block write position advances and wraps at the block size.
  assign pos_inc  = bw_pos + 6'd1;
  assign pos_wrap = ({1'b0, pos_inc} >= bs) ? 6'd0 : pos_inc;

  // Execution of one command step.
  always_comb begin
    ridx_next   = ridx;
    widx_next   = widx;
    cnt_next    = cnt;
    bw_pos_next = bw_pos;
    bw_ok_next  = bw_ok;
    ok_next     = 1'b1;
    sample_next = 32'd0;
    we          = 1'b0;
    blk_ok      = bw_ok;
    if (ctl.exec) begin
      case (cmd_q)
        CMD_WR_SAMPLE: begin
          ok_next = !full;
          if (!full) begin
            we        = 1'b1;
            widx_next = widx_inc;
            cnt_next  = cnt + CW'(1);
          end
        end
        CMD_RD_SAMPLE: begin
          ok_next = !empty;
          if (!empty) begin
            sample_next = rdata;
            ridx_next   = ridx_inc;
            cnt_next    = cnt - CW'(1);
          end
        end
        CMD_WR_BLOCK: begin
          // The first element reserves room for the whole block.
          blk_ok      = (bw_pos == 6'd0) ? room : bw_ok;
          bw_ok_next  = blk_ok;
          bw_pos_next = pos_wrap;
          ok_next     = blk_ok && !full;
          if (blk_ok && !full) begin
            we        = 1'b1;
            widx_next = widx_inc;
            cnt_next  = cnt + CW'(1);
          end
        end
        CMD_RD_BLOCK: begin
          if (ctl.first && !blk_avail) begin
            ok_next = 1'b0;
          end else begin
            sample_next = rdata;
            ridx_next   = ridx_inc;
            cnt_next    = cnt - CW'(1);
          end
        end
        CMD_DROP_SAMPLE: begin
          ok_next = !empty;
          if (!empty) begin
            ridx_next = ridx_inc;
            cnt_next  = cnt - CW'(1);
          end
        end
        CMD_DROP_BLOCK: begin
          ok_next = blk_avail;
          if (blk_avail) begin
            ridx_next = ridx_blk;
            cnt_next  = cnt - CW'(bs);
          end
        end
        CMD_CLEAR: begin
          ridx_next   = '0;
          widx_next   = '0;
          cnt_next    = '0;
          bw_pos_next = '0;
          bw_ok_next  = 1'b0;
        end
        default: begin
          ok_next = 1'b1;
        end
      endcase
    end
  end

  // Sample memory: one write port, registered read at the read index.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= sample_q;
    end
    rdata <= mem[ridx];
  end

  // Ring state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ridx   <= '0;
      widx   <= '0;
      cnt    <= '0;
      bw_pos <= '0;
      bw_ok  <= 1'b0;
    end else begin
      ridx   <= ridx_next;
      widx   <= widx_next;
      cnt    <= cnt_next;
      bw_pos <= bw_pos_next;
      bw_ok  <= bw_ok_next;
    end
  end

  // Input transfer and pending result.
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      cmd_q    <= cmd;
      sample_q <= sample_in;
    end
    if (ctl.exec) begin
      res_ok     <= ok_next;
      res_sample <= sample_next;
      res_last   <= ctl.last;
    end
  end

  // Counts, widened so the low bits can be taken at any depth.
  assign rd_x = OW'(cnt);
  assign wr_x = OW'(free);
  assign qr_x = OW'(quo_rd);
  assign qw_x = OW'(quo_wr);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ok               <= res_ok;
      sample_out       <= res_sample;
      last             <= res_last;
      samples_readable <= rd_x[CNT_OUT_W-1:0];
      samples_writable <= wr_x[CNT_OUT_W-1:0];
      blocks_readable  <= qr_x[CNT_OUT_W-1:0];
      blocks_writable  <= qw_x[CNT_OUT_W-1:0];
    end
  end

  // Divider operands and controller status.
  assign cnt_rd = cnt;
  assign cnt_wr = free;

  always_comb begin
    sts.cmd       = cmd_q;
    sts.blk_avail = blk_avail;
    sts.out_free  = !out_valid || !out_stall;
    sts.div_busy  = 1'b0;
    sts.bs        = bs;
  end

endmodule

// ===== rtl/block_ring_fifo.sv =====
// Top level of the block ring FIFO.
// Ring FIFO of DEPTH 32-bit samples with single-sample and whole-block
// commands; every result carries the readable and writable sample and block
// counts after it. Each command takes one input transfer and gives one
// result, except a successful block read, which gives block_size results
// with last on the final one. For each result the command executes, the
// divider is started, the bit-serial divider that forms the two block
// counts runs over CW = clog2(DEPTH + 1) bits (11 for the default depth),
// its finish is seen and the output register is loaded. The next input is
// taken while a result still waits in the output register. block_size is
// written through the register port at address 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// 0 acts as 1 and values above 64 act as 64.
module block_ring_fifo #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    cmd,
  input  logic [31:0]                   sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [31:0]                   sample_out,
  output logic                          last,
  output logic [brf_pkg::CNT_OUT_W-1:0] samples_readable,
  output logic [brf_pkg::CNT_OUT_W-1:0] samples_writable,
  output logic [brf_pkg::CNT_OUT_W-1:0] blocks_readable,
  output logic [brf_pkg::CNT_OUT_W-1:0] blocks_writable,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brf_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import brf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  brf_ctl_t        ctl;
  brf_sts_t        sts_dp;
  brf_sts_t        sts;
  logic [BS_W-1:0] bs;
  logic [CW-1:0]   cnt_rd;
  logic [CW-1:0]   cnt_wr;
  logic [CW-1:0]   quo_rd;
  logic [CW-1:0]   quo_wr;
  logic            div_busy;

  brf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bs      (bs)
  );

  brf_div #(.CW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num_a (cnt_rd),
    .num_b (cnt_wr),
    .den   (bs),
    .quo_a (quo_rd),
    .quo_b (quo_wr),
    .busy  (div_busy)
  );

  // Merge the divider state into the controller status.
  always_comb begin
    sts          = sts_dp;
    sts.div_busy = div_busy;
  end

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  brf_dp #(.DEPTH(DEPTH), .CW(CW)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts_dp),
    .bs               (bs),
    .cmd              (cmd),
    .sample_in        (sample_in),
    .cnt_rd           (cnt_rd),
    .cnt_wr           (cnt_wr),
    .quo_rd           (quo_rd),
    .quo_wr           (quo_wr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .ok               (ok),
    .sample_out       (sample_out),
    .last             (last),
    .samples_readable (samples_readable),
    .samples_writable (samples_writable),
    .blocks_readable  (blocks_readable),
    .blocks_writable  (blocks_writable)
  );

endmodule

// ===== rtl/brf_checker.sv =====
// Port-level checks for the block ring FIFO and their binding.
module brf_checker #(
  parameter int DEPTH = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          ok,
  input logic [31:0]                   sample_out,
  input logic                          last,
  input logic [brf_pkg::CNT_OUT_W-1:0] samples_readable,
  input logic [brf_pkg::CNT_OUT_W-1:0] samples_writable
);
  import brf_pkg::*;

  localparam logic [CNT_OUT_W-1:0] DEPTH_LOW = CNT_OUT_W'(DEPTH);

  // Stored plus free samples always make up the ring depth.
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_OUT_W'(samples_readable + samples_writable) == DEPTH_LOW))
    else $error("readable and writable counts do not add up to the depth");

  // A rejected command never returns a sample.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (sample_out == 32'd0))
    else $error("rejected result carries a sample");

  // Only a successful block read gives results that are not last.
  a_more_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> ok)
    else $error("intermediate result without success");

  // Once a command transfer is taken, the block works on it before the next.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a command is still at work");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind block_ring_fifo brf_checker #(.DEPTH(DEPTH)) u_brf_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .ok               (ok),
  .sample_out       (sample_out),
  .last             (last),
  .samples_readable (samples_readable),
  .samples_writable (samples_writable)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the block ring FIFO with directed and random command streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int DEPTH = 1024;
  localparam int IDX_W = 10;
  localparam int CLK_PERIOD = 2;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASE_ITEMS = 56;
  localparam logic [APB_AW-1:0] ADDR_BLOCK_SIZE = APB_AW'(4 * int'(REG_BLOCK_SIZE));

  // One result transfer as the block reports it.
  typedef struct packed {
    logic                 ok;
    logic [31:0]          word;
    logic                 last;
    logic [CNT_OUT_W-1:0] fill;
    logic [CNT_OUT_W-1:0] room;
    logic [CNT_OUT_W-1:0] fill_blocks;
    logic [CNT_OUT_W-1:0] room_blocks;
  } fifo_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           cmd = CMD_STATUS;
  logic [31:0]          sample_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 ok;
  logic [31:0]          sample_out;
  logic                 last;
  logic [CNT_OUT_W-1:0] samples_readable;
  logic [CNT_OUT_W-1:0] samples_writable;
  logic [CNT_OUT_W-1:0] blocks_readable;
  logic [CNT_OUT_W-1:0] blocks_writable;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  block_ring_fifo #(.DEPTH(DEPTH)) dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the ring contents and control state.
  logic [31:0]      ring_model [DEPTH];
  logic [IDX_W-1:0] head_idx = '0;
  logic [IDX_W-1:0] tail_idx = '0;
  logic             ring_full = 1'b0;
  logic [5:0]       blk_pos = '0;
  logic             blk_room_ok = 1'b0;
  logic [BS_W-1:0]  blk_size_reg = BS_RESET;

  fifo_result_t expected_q[$];
  int           errors = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           steady_mode = 1'b0;

  function automatic void report_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Gap length for either side; mostly short, a few long.
  function automatic int pick_gap();
    int roll;
    if (steady_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Block size as the block uses it: zero acts as one, above 64 acts as 64.
  function automatic int unsigned eff_block();
    if (blk_size_reg == 0) return 1;
    if (blk_size_reg > BS_MAX) return BS_MAX;
    return blk_size_reg;
  endfunction

  function automatic int unsigned fill_count();
    logic [IDX_W-1:0] diff;
    diff = tail_idx - head_idx;
    return ring_full ? DEPTH : int'(diff);
  endfunction

  function automatic logic store_sample(logic [31:0] word);
    if (ring_full) return 1'b0;
    ring_model[tail_idx] = word;
    tail_idx = tail_idx + 1'b1;
    if (tail_idx == head_idx) ring_full = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [31:0] take_sample();
    logic [31:0] word;
    word = ring_model[head_idx];
    head_idx = head_idx + 1'b1;
    ring_full = 1'b0;
    return word;
  endfunction

  // Queue one expected result, with the fill state as it stands now.
  function automatic void post_result(logic okv, logic [31:0] word, logic lastv);
    int unsigned fill, room, bs;
    fifo_result_t r;
    fill = fill_count();
    room = DEPTH - fill;
    bs = eff_block();
    r.ok = okv;
    r.word = word;
    r.last = lastv;
    r.fill = CNT_OUT_W'(fill);
    r.room = CNT_OUT_W'(room);
    r.fill_blocks = CNT_OUT_W'(fill / bs);
    r.room_blocks = CNT_OUT_W'(room / bs);
    expected_q.push_back(r);
  endfunction

  // Apply one accepted command to the mirror and queue its results.
  function automatic void predict_command(logic [2:0] c, logic [31:0] d);
    int unsigned bs;
    logic accepted;
    logic [31:0] word;
    bs = eff_block();
    accepted = 1'b0;
    case (c)
      CMD_WR_SAMPLE: begin
        accepted = store_sample(d);
        post_result(accepted, '0, 1'b1);
      end
      CMD_RD_SAMPLE: begin
        if (fill_count() == 0) begin
          post_result(1'b0, '0, 1'b1);
        end else begin
          word = take_sample();
          post_result(1'b1, word, 1'b1);
        end
      end
      CMD_WR_BLOCK: begin
        // The first element reserves room for the whole block.
        if (blk_pos == 0) blk_room_ok = (DEPTH - fill_count()) / bs > 0;
        if (blk_room_ok) accepted = store_sample(d);
        blk_pos = blk_pos + 6'd1;
        if (blk_pos >= bs) blk_pos = '0;
        post_result(accepted, '0, 1'b1);
      end
      CMD_RD_BLOCK: begin
        if (fill_count() / bs == 0) begin
          post_result(1'b0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < bs; i++) begin
            word = take_sample();
            post_result(1'b1, word, i + 1 == bs);
          end
        end
      end
      CMD_DROP_SAMPLE: begin
        accepted = fill_count() > 0;
        if (accepted) void'(take_sample());
        post_result(accepted, '0, 1'b1);
      end
      CMD_DROP_BLOCK: begin
        accepted = fill_count() / bs > 0;
        if (accepted) begin
          for (int unsigned i = 0; i < bs; i++) void'(take_sample());
        end
        post_result(accepted, '0, 1'b1);
      end
      CMD_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        ring_full = 1'b0;
        blk_pos = '0;
        blk_room_ok = 1'b0;
        post_result(1'b1, '0, 1'b1);
      end
      default: post_result(1'b1, '0, 1'b1);
    endcase
  endfunction

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin : check_result
    fifo_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{ok, sample_out, last, samples_readable, samples_writable,
              blocks_readable, blocks_writable};
      if (expected_q.size() == 0) begin
        report_error($sformatf("Unexpected result transfer at cycle %0d: ok=%0b sample=%h",
                               cycle_count, got.ok, got.word));
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          report_error($sformatf({"Result mismatch at cycle %0d: expected ok=%0b sample=%h ",
                                  "last=%0b fill=%0d room=%0d blocks=%0d/%0d, got ok=%0b ",
                                  "sample=%h last=%0b fill=%0d room=%0d blocks=%0d/%0d"},
                                 cycle_count, want.ok, want.word, want.last, want.fill,
                                 want.room, want.fill_blocks, want.room_blocks, got.ok,
                                 got.word, got.last, got.fill, got.room, got.fill_blocks,
                                 got.room_blocks));
        end
      end
    end
  end

  // Random backpressure on the result side.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      stall_left = pick_gap();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one command and hold it until the transfer completes.
  task automatic send_item(input logic [2:0] c, input logic [31:0] d);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    sample_in = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(c, d);
    items_sent++;
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic await_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = addr;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Reprogram the block size once the block is idle, then read it back.
  task automatic set_block_size(input logic [BS_W-1:0] value);
    logic [31:0] readback;
    await_idle();
    apb_write(ADDR_BLOCK_SIZE, 32'(value));
    blk_size_reg = value;
    apb_read(ADDR_BLOCK_SIZE, readback);
    if (readback[BS_W-1:0] != value) begin
      report_error($sformatf("Block size readback: expected %0d, got %0d",
                             value, readback[BS_W-1:0]));
    end
  endtask

  // Every reading and dropping command on an empty ring is rejected.
  task automatic test_empty_ring();
    logic [31:0] readback;
    apb_read(ADDR_BLOCK_SIZE, readback);
    if (readback[BS_W-1:0] != BS_RESET) begin
      report_error($sformatf("Block size after reset: expected %0d, got %0d",
                             BS_RESET, readback[BS_W-1:0]));
    end
    send_item(CMD_STATUS, '0);
    send_item(CMD_RD_SAMPLE, '0);
    send_item(CMD_RD_BLOCK, '0);
    send_item(CMD_DROP_SAMPLE, '0);
    send_item(CMD_DROP_BLOCK, '0);
  endtask

  // Single sample writes, reads and drops with extreme words.
  task automatic test_single_samples();
    send_item(CMD_WR_SAMPLE, 32'h0000_0000);
    send_item(CMD_WR_SAMPLE, 32'hFFFF_FFFF);
    send_item(CMD_WR_SAMPLE, 32'h5A5A_A5A5);
    send_item(CMD_RD_SAMPLE, '0);
    send_item(CMD_DROP_SAMPLE, '0);
    send_item(CMD_RD_SAMPLE, '0);
  endtask

  // Whole block write, read and drop, and a clear in the middle of a block write.
  task automatic test_block_commands();
    set_block_size(7'd4);
    repeat (4) send_item(CMD_WR_BLOCK, $urandom());
    send_item(CMD_RD_BLOCK, '0);
    repeat (4) send_item(CMD_WR_BLOCK, $urandom());
    send_item(CMD_DROP_BLOCK, '0);
    repeat (2) send_item(CMD_WR_BLOCK, $urandom());
    send_item(CMD_CLEAR, '0);
    send_item(CMD_STATUS, '0);
  endtask

  // A block size change in the middle of a block write, and the extreme sizes.
  task automatic test_block_size_change();
    set_block_size(7'd8);
    repeat (3) send_item(CMD_WR_BLOCK, $urandom());
    set_block_size(7'd2);
    send_item(CMD_WR_BLOCK, $urandom());
    repeat (2) send_item(CMD_WR_BLOCK, $urandom());
    send_item(CMD_RD_BLOCK, '0);
    send_item(CMD_RD_BLOCK, '0);
    set_block_size(7'd0);
    send_item(CMD_WR_SAMPLE, $urandom());
    send_item(CMD_RD_BLOCK, '0);
    set_block_size(7'd127);
    send_item(CMD_STATUS, '0);
  endtask

  // The largest block: written element by element, read back by one command, then a
  // drop on the empty ring is refused.
  task automatic test_largest_block();
    set_block_size(BS_MAX);
    steady_mode = 1'b1;
    send_item(CMD_CLEAR, '0);
    repeat (BS_MAX) send_item(CMD_WR_BLOCK, $urandom());
    send_item(CMD_RD_BLOCK, '0);
    send_item(CMD_DROP_BLOCK, '0);
    send_item(CMD_CLEAR, '0);
    steady_mode = 1'b0;
  endtask

  // One random operation; block writes are mostly whole blocks.
  task automatic random_op();
    int pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = eff_block();
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 11) == 0) send_item(3'($urandom_range(0, 7)), $urandom());
        send_item(CMD_WR_BLOCK, $urandom());
      end
    end else if (pick < 55) begin
      send_item(CMD_WR_SAMPLE, $urandom());
    end else if (pick < 65) begin
      send_item(CMD_RD_SAMPLE, $urandom());
    end else if (pick < 75) begin
      send_item(CMD_RD_BLOCK, $urandom());
    end else if (pick < 80) begin
      send_item(CMD_DROP_SAMPLE, $urandom());
    end else if (pick < 85) begin
      send_item(CMD_DROP_BLOCK, $urandom());
    end else if (pick < 88) begin
      send_item(CMD_CLEAR, $urandom());
    end else if (pick < 92) begin
      send_item(CMD_STATUS, $urandom());
    end else begin
      send_item(3'($urandom_range(0, 7)), $urandom());
    end
  endtask

  task automatic test_random_traffic(input logic [BS_W-1:0] bs_value, input bit steady);
    int start;
    set_block_size(bs_value);
    steady_mode = steady;
    start = items_sent;
    while (items_sent - start < RANDOM_PHASE_ITEMS) random_op();
    steady_mode = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;
    test_empty_ring();
    test_single_samples();
    test_block_commands();
    test_block_size_change();
    test_largest_block();
    test_random_traffic(7'd3, 1'b0);
    test_random_traffic(7'd1, 1'b0);
    test_random_traffic(7'd5, 1'b1);
    test_random_traffic(7'($urandom_range(0, 127)), 1'b0);
    test_random_traffic(7'd2, 1'b0);
    await_idle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
